[design/decimal_int_text_parser_defines.svh]
// assertion macros for the parser top level
`ifndef DECIMAL_INT_TEXT_PARSER_DEFINES_SVH
`define DECIMAL_INT_TEXT_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DITP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// next-cycle implication, checked out of reset
`define DITP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

[design/ditp_pkg.sv]
package ditp_pkg;

  localparam int unsigned MAG_W = 31;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_TRAIL = 3'd2;
  localparam logic [2:0] PH_BAD   = 3'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] value;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic             minus_seen;
    logic             digit_seen;
    logic [MAG_W-1:0] magnitude;
  } ditp_state_t;

  localparam ditp_state_t STATE_RESET = '{
    phase:      PH_LEAD,
    minus_seen: 1'b0,
    digit_seen: 1'b0,
    magnitude:  '0
  };

endpackage

[design/ditp_step.sv]
module ditp_step (
  input  ditp_pkg::ditp_state_t state,
  input  ditp_pkg::in_item_t    item,
  output ditp_pkg::ditp_state_t state_nxt,
  output ditp_pkg::out_item_t   result
);
  import ditp_pkg::*;

  logic             is_blank;
  logic             is_digit;
  logic [3:0]       digit_val;
  logic [MAG_W+3:0] mag_sum;
  logic             mag_over;
  logic             str_ok;
  logic [31:0]      mag_ext;

  assign is_blank  = (item.ch == CH_SPACE) || ((item.ch >= CH_TAB) && (item.ch <= CH_CR));
  assign is_digit  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign digit_val = 4'(item.ch - CH_ZERO);

  // magnitude * 10 as (m << 3) + (m << 1), then add the digit
  assign mag_sum  = {1'b0, state.magnitude, 3'b000} + {3'b000, state.magnitude, 1'b0}
                  + {{MAG_W{1'b0}}, digit_val};
  assign mag_over = |mag_sum[MAG_W+3:MAG_W];

  assign str_ok  = (state.phase <= PH_TRAIL) && state.digit_seen;
  assign mag_ext = {1'b0, state.magnitude};

  always_comb begin
    result.ok    = str_ok;
    result.value = '0;
    if (str_ok) begin
      result.value = state.minus_seen ? $signed(32'd0 - mag_ext) : $signed(mag_ext);
    end
  end

  always_comb begin
    state_nxt = state;
    if (item.end_of_text) begin
      state_nxt = STATE_RESET;
    end else begin
      unique case (state.phase)
        PH_LEAD: begin
          if (is_blank) begin
            state_nxt.phase = PH_LEAD;
          end else if (item.ch == CH_MINUS) begin
            state_nxt.minus_seen = 1'b1;
            state_nxt.phase      = PH_BODY;
          end else if (item.ch == CH_PLUS) begin
            state_nxt.phase = PH_BODY;
          end else if (is_digit && !mag_over) begin
            state_nxt.magnitude  = mag_sum[MAG_W-1:0];
            state_nxt.digit_seen = 1'b1;
            state_nxt.phase      = PH_BODY;
          end else begin
            state_nxt.phase = PH_BAD;
          end
        end
        PH_BODY: begin
          if (is_digit && !mag_over) begin
            state_nxt.magnitude  = mag_sum[MAG_W-1:0];
            state_nxt.digit_seen = 1'b1;
          end else if (is_blank) begin
            state_nxt.phase = PH_TRAIL;
          end else begin
            state_nxt.phase = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!is_blank) begin
            state_nxt.phase = PH_BAD;
          end
        end
        default: begin
          state_nxt.phase = PH_BAD;
        end
      endcase
    end
  end

endmodule

[design/decimal_int_text_parser.sv]
// decimal integer text parser
// in channel: one text byte per item (in_item.ch); an item with
//   in_item.end_of_text set closes the string and its ch is ignored
// out channel: one item per string, given for the terminator only:
//   out_item.ok and the signed 32-bit out_item.value (0 when not ok)
// throughput: one byte item per cycle while no terminator waits on the
//   output register; a combinational multiply-by-ten and add updates the magnitude
// path: an accepted item is held in the input register; a terminator's
//   result is loaded from there into the output register once that
//   register is free, and out_valid rises with it
// stall: while a result waits in the output register, byte items keep
//   flowing; a following terminator waits in the input register and
//   in_ready drops until out_ready frees the output register
// reset: synchronous active-low rst_n empties both registers and puts
//   the parser back in the leading whitespace phase with no sign, no
//   digit and a zero magnitude
`include "decimal_int_text_parser_defines.svh"

module decimal_int_text_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ditp_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ditp_pkg::out_item_t out_item
);
  import ditp_pkg::*;

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  ditp_state_t state_r;
  ditp_state_t state_nxt;
  out_item_t   result;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        slot_free;
  logic        s1_adv;
  logic        s1_eot_adv;

  ditp_step u_step (
    .state     (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign slot_free  = !out_valid_r || out_ready;
  // byte items never need the output slot, only the terminator does
  assign s1_adv     = s1_valid_r && (!s1_item_r.end_of_text || slot_free);
  assign s1_eot_adv = s1_adv && s1_item_r.end_of_text;
  assign in_ready   = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_eot_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (s1_eot_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `DITP_ASSERT_IMP(a_bad_zero, out_valid_r && !out_item_r.ok, out_item_r.value == 32'sd0)
  `DITP_ASSERT_IMP(a_ok_range, out_valid_r && out_item_r.ok, out_item_r.value != 32'sh80000000)
  `DITP_ASSERT_IMP(a_phase_code, 1'b1, state_r.phase <= PH_BAD)
  `DITP_ASSERT_IMP(a_no_digit_zero, !state_r.digit_seen, state_r.magnitude == '0)
  `DITP_ASSERT_NXT(a_eot_clears, s1_eot_adv, state_r == STATE_RESET && out_valid_r)
  `DITP_ASSERT_IMP(a_eot_waits, s1_valid_r && s1_item_r.end_of_text && !slot_free, !in_ready)

endmodule
